>>> rtl/core/assert_macros.svh
// assertion helpers used by the rtl sequencer unit
// each macro expects clk_i and rst_ni in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define EOS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be seen outside reset
`define EOS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

>>> rtl/core/eos_pkg.sv
// ----------------------------------------------------------------------------
// eos_pkg
// Shared widths and constants of the eased offset sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package eos_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned SlotW    = 4;
  localparam int unsigned CountW   = 5;
  localparam int unsigned AxisNum  = 5;
  localparam int unsigned MaxMoves = 16;
  localparam int unsigned FracW    = 16;

  // one move in the table: trigger, duration, then the five axis targets
  localparam int unsigned MoveW    = (AxisNum + 2) * DataW;

  localparam logic [FracW:0] OneQ16  = 17'h1_0000;
  localparam logic [FracW:0] HalfQ16 = 17'h0_8000;

  typedef logic [DataW-1:0] word_t;

endpackage

`default_nettype wire

>>> rtl/core/eos_if.sv
// ----------------------------------------------------------------------------
// eos_if
// Channel interfaces: tick/load items in, delta items out, count register.
// ----------------------------------------------------------------------------
`default_nettype none

interface eos_in_if;
  logic                            valid;
  logic                            ready;
  logic                            operation;
  logic [eos_pkg::SlotW-1:0]       slot;
  logic signed [eos_pkg::DataW-1:0] trigger_position;
  logic [eos_pkg::DataW-1:0]       duration;
  logic signed [eos_pkg::DataW-1:0] target_x;
  logic signed [eos_pkg::DataW-1:0] target_y;
  logic signed [eos_pkg::DataW-1:0] target_z;
  logic signed [eos_pkg::DataW-1:0] target_yaw;
  logic signed [eos_pkg::DataW-1:0] target_pitch;
  logic [eos_pkg::DataW-1:0]       tick_time;
  logic signed [eos_pkg::DataW-1:0] current_position;

  modport source (
    output valid, operation, slot, trigger_position, duration, target_x, target_y,
           target_z, target_yaw, target_pitch, tick_time, current_position,
    input  ready
  );
  modport sink (
    input  valid, operation, slot, trigger_position, duration, target_x, target_y,
           target_z, target_yaw, target_pitch, tick_time, current_position,
    output ready
  );
endinterface

interface eos_out_if;
  logic                            valid;
  logic                            ready;
  logic signed [eos_pkg::DataW-1:0] delta_x;
  logic signed [eos_pkg::DataW-1:0] delta_y;
  logic signed [eos_pkg::DataW-1:0] delta_z;
  logic signed [eos_pkg::DataW-1:0] delta_yaw;
  logic signed [eos_pkg::DataW-1:0] delta_pitch;
  logic                            moved;
  logic                            sequence_done;

  modport source (
    output valid, delta_x, delta_y, delta_z, delta_yaw, delta_pitch, moved,
           sequence_done,
    input  ready
  );
  modport sink (
    input  valid, delta_x, delta_y, delta_z, delta_yaw, delta_pitch, moved,
           sequence_done,
    output ready
  );
endinterface

interface eos_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [eos_pkg::CountW-1:0] move_count;

  modport source (output valid, move_count, input ready);
  modport sink (input valid, move_count, output ready);
endinterface

`default_nettype wire

>>> rtl/core/eos_ram.sv
// ----------------------------------------------------------------------------
// eos_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module eos_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> rtl/core/eos_div.sv
// ----------------------------------------------------------------------------
// eos_div
// Restoring divider, one quotient bit a cycle. Dividend must be below divisor,
// quotient is floor(dividend * 2^16 / divisor).
// ----------------------------------------------------------------------------
`default_nettype none

module eos_div (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire eos_pkg::word_t             dividend_i,
  input  wire eos_pkg::word_t             divisor_i,
  output logic                            done_o,
  output logic [eos_pkg::FracW-1:0]       quot_o
);

  localparam int unsigned CntW = $clog2(eos_pkg::FracW + 1);

  logic [eos_pkg::DataW-1:0] rem_q;
  logic [eos_pkg::DataW-1:0] dsr_q;
  logic [CntW-1:0]           cnt_q;
  logic                      busy_q;
  logic                      done_q;
  logic [eos_pkg::FracW-1:0] quot_q;
  logic [eos_pkg::DataW:0]   shifted;
  logic                      fits;

  assign shifted = {rem_q, 1'b0};
  assign fits    = shifted >= {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(eos_pkg::FracW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= dividend_i;
      dsr_q  <= divisor_i;
      quot_q <= '0;
    end else if (busy_q) begin
      // remainder stays below the divisor, so it fits in one word
      rem_q  <= fits ? eos_pkg::DataW'(shifted - {1'b0, dsr_q})
                     : shifted[eos_pkg::DataW-1:0];
      quot_q <= {quot_q[eos_pkg::FracW-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

>>> rtl/core/eos_mul.sv
// ----------------------------------------------------------------------------
// eos_mul
// Shared 32 x 32 unsigned multiplier with registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module eos_mul (
  input  wire logic                          clk_i,
  input  wire logic                          en_i,
  input  wire eos_pkg::word_t                a_i,
  input  wire eos_pkg::word_t                b_i,
  output logic [2*eos_pkg::DataW-1:0]        prod_o
);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_o <= a_i * b_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/eased_offset_sequencer_unit.sv
// ----------------------------------------------------------------------------
// eased_offset_sequencer_unit
// Plays loaded moves in order, easing five axes with quadratic in-out easing
// and returning each tick's per-axis change.
// ----------------------------------------------------------------------------
//  port    dir  handshake    payload
//  cfg_i   in   valid/ready  move_count, restarts the sequence
//  in_i    in   valid/ready  tick or load item
//  res_o   out  valid/ready  five deltas, moved, sequence_done
//
//  a load item or a tick with no move left goes through the out state to the
//  result register, and a tick below the trigger passes the read state first
//  moving tick: read, then waiting on the bit-serial divider and on the
//  shared multiplier (one square, then one product per axis); a move that
//  completes goes from read to the square without a divide
//  in_i is ready only in the idle state; one finished item may wait in the
//  result register while the next item is taken
//  reset clears control and run state; table contents are undefined until loaded
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module eased_offset_sequencer_unit #(
  parameter int unsigned MaxMoves = eos_pkg::MaxMoves
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  eos_cfg_if.sink    cfg_i,
  eos_in_if.sink     in_i,
  eos_out_if.source  res_o
);

  localparam int unsigned IdxW  = (MaxMoves > 1) ? $clog2(MaxMoves) : 1;
  localparam int unsigned CntW  = $clog2(MaxMoves + 1);
  localparam int unsigned DW    = eos_pkg::DataW;
  localparam int unsigned AxW   = $clog2(eos_pkg::AxisNum);
  localparam int unsigned PW    = eos_pkg::FracW + 1;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRead = 3'd1;
  localparam logic [2:0] StDiv  = 3'd2;
  localparam logic [2:0] StSq   = 3'd3;
  localparam logic [2:0] StSqW  = 3'd4;
  localparam logic [2:0] StAx   = 3'd5;
  localparam logic [2:0] StAxW  = 3'd6;
  localparam logic [2:0] StOut  = 3'd7;

  logic [2:0]                state_q;
  logic [eos_pkg::CountW-1:0] count_q;
  logic [CntW-1:0]           index_q;
  logic [DW-1:0]             elapsed_q;
  logic signed [DW-1:0]      prev_q  [eos_pkg::AxisNum];
  logic signed [DW-1:0]      delta_q [eos_pkg::AxisNum];
  logic                      moved_q;
  logic [PW-1:0]             p_q;
  logic [DW:0]               factor_q;
  logic [AxW-1:0]            axis_q;
  logic signed [DW-1:0]      pos_q;
  logic [DW-1:0]             tick_q;
  logic                      out_valid_q;
  logic signed [DW-1:0]      out_delta_q [eos_pkg::AxisNum];
  logic                      out_moved_q;
  logic                      out_done_q;

  logic [CntW-1:0]           cnt_eff;
  logic                      in_acc;
  logic                      ram_we;
  logic [eos_pkg::MoveW-1:0] ram_wdata;
  logic [eos_pkg::MoveW-1:0] ram_rdata;
  logic signed [DW-1:0]      trig;
  logic [DW-1:0]             dur;
  logic [DW:0]               esum;
  logic [DW-1:0]             esat;
  logic                      div_start;
  logic                      div_done;
  logic [eos_pkg::FracW-1:0] div_quot;
  logic                      p_low;
  logic [PW-1:0]             q_val;
  logic                      mul_en;
  eos_pkg::word_t            mul_a;
  eos_pkg::word_t            mul_b;
  logic [2*DW-1:0]           mul_prod;
  logic [DW:0]               two_sq;
  logic signed [DW-1:0]      tgt [eos_pkg::AxisNum];
  logic signed [DW-1:0]      cur_tgt;
  logic                      neg;
  logic [DW-1:0]             mag;
  logic [2*DW-1:0]           rsum;
  logic [DW-1:0]             r_val;
  logic signed [DW:0]        nv;
  logic signed [DW+1:0]      diff;
  logic signed [DW-1:0]      dsat;

  assign cnt_eff = (32'(count_q) > 32'(MaxMoves)) ? CntW'(MaxMoves) : CntW'(count_q);

  assign in_i.ready  = (state_q == StIdle);
  assign cfg_i.ready = 1'b1;
  assign in_acc      = in_i.valid && in_i.ready;

  // table row: trigger, duration, then x, y, z, yaw, pitch
  assign ram_wdata = {in_i.target_pitch, in_i.target_yaw, in_i.target_z,
                      in_i.target_y, in_i.target_x, in_i.duration, in_i.trigger_position};
  assign ram_we    = in_acc && in_i.operation && (32'(in_i.slot) < 32'(MaxMoves));

  eos_ram #(
    .Width (eos_pkg::MoveW),
    .Depth (MaxMoves)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (IdxW'(in_i.slot)),
    .wdata_i (ram_wdata),
    .raddr_i (IdxW'(index_q)),
    .rdata_o (ram_rdata)
  );

  assign trig = ram_rdata[DW-1:0];
  assign dur  = ram_rdata[2*DW-1:DW];

  always_comb begin
    for (int a = 0; a < int'(eos_pkg::AxisNum); a++) begin
      tgt[a] = ram_rdata[(a+2)*DW +: DW];
    end
  end

  // saturating time accumulation
  assign esum = {1'b0, elapsed_q} + {1'b0, tick_q};
  assign esat = esum[DW] ? '1 : esum[DW-1:0];

  assign div_start = (state_q == StRead) && (pos_q >= trig) &&
                     (dur != '0) && (esat < dur);

  eos_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (esat),
    .divisor_i  (dur),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // ease in-out: mirror the upper half of progress
  assign p_low = p_q < eos_pkg::HalfQ16;
  assign q_val = p_low ? p_q : eos_pkg::OneQ16 - p_q;

  assign cur_tgt = tgt[axis_q];
  assign neg     = cur_tgt[DW-1];
  assign mag     = neg ? DW'(-cur_tgt) : cur_tgt;

  assign mul_en = (state_q == StSq) || (state_q == StAx);
  assign mul_a  = (state_q == StSq) ? DW'(q_val) : mag;
  assign mul_b  = (state_q == StSq) ? DW'(q_val) : factor_q[DW-1:0];

  eos_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (mul_prod)
  );

  assign two_sq = {mul_prod[DW-1:0], 1'b0};

  // round to nearest, halves away from zero; a full factor gives the target
  assign rsum  = mul_prod + 64'h0000_0000_8000_0000;
  assign r_val = factor_q[DW] ? mag : rsum[2*DW-1:DW];
  assign nv    = neg ? -$signed({1'b0, r_val}) : $signed({1'b0, r_val});
  assign diff  = (DW+2)'(nv) - (DW+2)'(prev_q[axis_q]);

  always_comb begin
    if (diff > (DW+2)'(32'sh7fff_ffff)) begin
      dsat = 32'sh7fff_ffff;
    end else if (diff < -(DW+2)'(33'sh0_8000_0000)) begin
      dsat = 32'sh8000_0000;
    end else begin
      dsat = diff[DW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      index_q     <= '0;
      elapsed_q   <= '0;
      out_valid_q <= 1'b0;
      moved_q     <= 1'b0;
      axis_q      <= '0;
      for (int a = 0; a < int'(eos_pkg::AxisNum); a++) begin
        prev_q[a] <= '0;
      end
    end else begin
      if (out_valid_q && res_o.ready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        StIdle: begin
          if (in_acc) begin
            moved_q <= 1'b0;
            for (int a = 0; a < int'(eos_pkg::AxisNum); a++) begin
              delta_q[a] <= '0;
            end
            pos_q  <= in_i.current_position;
            tick_q <= in_i.tick_time;
            if (!in_i.operation && (index_q < cnt_eff)) begin
              state_q <= StRead;
            end else begin
              state_q <= StOut;
            end
          end
        end
        StRead: begin
          if (pos_q < trig) begin
            state_q <= StOut;
          end else begin
            elapsed_q <= esat;
            if ((dur == '0) || (esat >= dur)) begin
              p_q     <= eos_pkg::OneQ16;
              state_q <= StSq;
            end else begin
              state_q <= StDiv;
            end
          end
        end
        StDiv: begin
          if (div_done) begin
            p_q     <= {1'b0, div_quot};
            state_q <= StSq;
          end
        end
        StSq: begin
          state_q <= StSqW;
        end
        StSqW: begin
          factor_q <= p_low ? two_sq : {1'b1, {DW{1'b0}}} - two_sq;
          axis_q   <= '0;
          state_q  <= StAx;
        end
        StAx: begin
          state_q <= StAxW;
        end
        StAxW: begin
          delta_q[axis_q] <= dsat;
          prev_q[axis_q]  <= nv[DW-1:0];
          if (axis_q == AxW'(eos_pkg::AxisNum - 1)) begin
            moved_q <= 1'b1;
            state_q <= StOut;
            if (p_q == eos_pkg::OneQ16) begin
              index_q   <= index_q + 1'b1;
              elapsed_q <= '0;
              for (int a = 0; a < int'(eos_pkg::AxisNum); a++) begin
                prev_q[a] <= '0;
              end
            end
          end else begin
            axis_q  <= axis_q + 1'b1;
            state_q <= StAx;
          end
        end
        StOut: begin
          if (!out_valid_q || res_o.ready) begin
            out_valid_q <= 1'b1;
            out_moved_q <= moved_q;
            out_done_q  <= index_q >= cnt_eff;
            for (int a = 0; a < int'(eos_pkg::AxisNum); a++) begin
              out_delta_q[a] <= delta_q[a];
            end
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase

      // a count write restarts the sequence
      if (cfg_i.valid && cfg_i.ready) begin
        count_q   <= cfg_i.move_count;
        index_q   <= '0;
        elapsed_q <= '0;
        for (int a = 0; a < int'(eos_pkg::AxisNum); a++) begin
          prev_q[a] <= '0;
        end
      end
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.delta_x       = out_delta_q[0];
  assign res_o.delta_y       = out_delta_q[1];
  assign res_o.delta_z       = out_delta_q[2];
  assign res_o.delta_yaw     = out_delta_q[3];
  assign res_o.delta_pitch   = out_delta_q[4];
  assign res_o.moved         = out_moved_q;
  assign res_o.sequence_done = out_done_q;

  `EOS_ASSERT(a_index_in_range, index_q <= cnt_eff, "move index beyond move count")
  `EOS_ASSERT_NEVER(a_div_done_stray, div_done && (state_q != StDiv),
                    "divider done outside divide")
  `EOS_ASSERT(a_out_from_out_state, $rose(out_valid_q) |-> ($past(state_q) == StOut),
              "result without out state")
  `EOS_ASSERT(a_advance_clears_time, (index_q != $past(index_q)) |-> (elapsed_q == '0),
              "advance left time")

endmodule

`default_nettype wire

>>> tb/eos_tb_if.sv
// ----------------------------------------------------------------------------
// eos_tb_if
// Note: the channel interfaces come from the rtl file eos_if.sv; this file
// only holds shared testbench types for the eased offset sequencer bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

package eos_tb_pkg;

  typedef enum logic {OP_TICK = 1'b0, OP_LOAD = 1'b1} op_e;

  typedef struct {
    op_e         op;
    logic [3:0]  slot;
    logic [31:0] trig;
    logic [31:0] dur;
    logic [31:0] tgt [5];
    logic [31:0] tick;
    logic [31:0] pos;
    int          cfg;   // -1: plain item, else only a count write of this value
    bit          drain; // wait for every expected result before this item
  } stim_t;

  typedef struct {
    logic [31:0] d [5];
    logic        moved;
    logic        done;
  } delta_t;

endpackage

>>> tb/tb_eased_offset_sequencer_unit.sv
// ----------------------------------------------------------------------------
// tb_eased_offset_sequencer_unit
// Random and directed ticks and loads against a behavioral easing predictor,
// with count writes between phases and random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_eased_offset_sequencer_unit;

  localparam int Latency = 60;
  localparam int WatchLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #5 clk_i = ~clk_i;

  eos_cfg_if cfg_ch ();
  eos_in_if  in_ch ();
  eos_out_if res_ch ();

  eased_offset_sequencer_unit u_top (
    .clk_i (clk_i), .rst_ni(rst_ni), .cfg_i(cfg_ch.sink), .in_i(in_ch.sink),
    .res_o (res_ch.source)
  );

  // predictor state
  logic [31:0] trig_tab [16];
  logic [31:0] dur_tab [16];
  logic [31:0] axis_tab [5][16];
  int          cnt_reg, idx_reg;
  logic [31:0] elapsed_acc;
  longint      prev_off [5];

  eos_tb_pkg::stim_t  pending_items[$];
  eos_tb_pkg::delta_t expected_deltas[$];
  int     errors = 0;
  int     send_idle = 0, recv_stall = 0;
  bit     cfg_busy = 0;
  int     quiet_cycles = 0;
  bit     in_fire = 0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
    $display("mismatch %s: got %h expected %h at %0t", what, got, exp, $realtime);
    errors++;
  endtask

  function automatic int eff_count();
    return cnt_reg > 16 ? 16 : cnt_reg;
  endfunction

  function automatic void restart_run(input int c);
    cnt_reg = c;
    idx_reg = 0;
    elapsed_acc = '0;
    for (int a = 0; a < 5; a++) prev_off[a] = 0;
  endfunction

  function automatic eos_tb_pkg::delta_t predict_delta(input eos_tb_pkg::stim_t s);
    eos_tb_pkg::delta_t r;
    longint unsigned sum, p, f, q, mag, rr;
    longint nv, dl;
    int m;
    for (int a = 0; a < 5; a++) r.d[a] = '0;
    r.moved = 1'b0;
    if (s.op == eos_tb_pkg::OP_LOAD) begin
      trig_tab[s.slot] = s.trig;
      dur_tab[s.slot] = s.dur;
      for (int a = 0; a < 5; a++) axis_tab[a][s.slot] = s.tgt[a];
    end else if (idx_reg < eff_count()) begin
      m = idx_reg;
      if ($signed(s.pos) >= $signed(trig_tab[m])) begin
        sum = longint'(elapsed_acc) + longint'(s.tick);
        elapsed_acc = sum > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : sum[31:0];
        if (dur_tab[m] == 0) p = 65536;
        else begin
          p = (longint'(elapsed_acc) << 16) / longint'(dur_tab[m]);
          if (p > 65536) p = 65536;
        end
        if (p < 32768) f = 2 * p * p;
        else begin
          q = 65536 - p;
          f = (64'd1 << 32) - 2 * q * q;
        end
        for (int a = 0; a < 5; a++) begin
          nv = longint'($signed(axis_tab[a][m]));
          mag = nv < 0 ? -nv : nv;
          rr = (mag * f + 64'h8000_0000) >> 32;
          nv = nv < 0 ? -longint'(rr) : longint'(rr);
          dl = nv - prev_off[a];
          if (dl > 64'sd2147483647) dl = 64'sd2147483647;
          if (dl < -64'sd2147483648) dl = -64'sd2147483648;
          r.d[a] = dl[31:0];
          prev_off[a] = nv;
        end
        r.moved = 1'b1;
        if (p >= 65536) begin
          idx_reg = m + 1;
          elapsed_acc = '0;
          for (int a = 0; a < 5; a++) prev_off[a] = 0;
        end
      end
    end
    r.done = idx_reg >= eff_count();
    return r;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(0, 4) - 2;
      default: return $urandom();
    endcase
  endfunction

  function automatic eos_tb_pkg::stim_t blank_item();
    eos_tb_pkg::stim_t s;
    s.op = eos_tb_pkg::OP_TICK;
    s.slot = '0;
    s.trig = '0;
    s.dur = '0;
    for (int a = 0; a < 5; a++) s.tgt[a] = '0;
    s.tick = '0;
    s.pos = '0;
    s.cfg = -1;
    s.drain = 0;
    return s;
  endfunction

  function automatic void push_load(input int sl, input logic [31:0] tr,
                                    input logic [31:0] du, input bit wide);
    eos_tb_pkg::stim_t s = blank_item();
    s.op = eos_tb_pkg::OP_LOAD;
    s.slot = 4'(sl);
    s.trig = tr;
    s.dur = du;
    for (int a = 0; a < 5; a++)
      s.tgt[a] = wide ? rand_word() : 32'($signed($urandom_range(0, 200000)) - 100000);
    pending_items.push_back(s);
  endfunction

  function automatic void push_tick(input logic [31:0] tk, input logic [31:0] ps);
    eos_tb_pkg::stim_t s = blank_item();
    s.tick = tk;
    s.pos = ps;
    pending_items.push_back(s);
  endfunction

  function automatic void push_cfg(input int c);
    eos_tb_pkg::stim_t s = blank_item();
    s.cfg = c;
    pending_items.push_back(s);
  endfunction

  // driver: a count write only goes out once the block is idle
  eos_tb_pkg::stim_t cur;
  bit    have_cur = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (cfg_busy) begin
        if (cfg_ch.valid && cfg_ch.ready) begin
          cfg_ch.valid <= 1'b0;
          cfg_busy = 0;
        end
      end else begin
        // in_fire holds the handshake seen at the last rising edge
        if (in_fire) have_cur = 0;
        if (!have_cur && pending_items.size() > 0) begin
          if ((pending_items[0].cfg >= 0 || pending_items[0].drain)
              && expected_deltas.size() > 0) begin
            quiet_cycles = 0;
          end else if (pending_items[0].cfg >= 0) begin
            if (quiet_cycles >= Latency) begin
              cur = pending_items.pop_front();
              restart_run(cur.cfg);
              cfg_ch.move_count <= cur.cfg[4:0];
              cfg_ch.valid <= 1'b1;
              cfg_busy = 1;
            end else quiet_cycles++;
          end else if ($urandom_range(0, 99) >= send_idle) begin
            cur = pending_items.pop_front();
            have_cur = 1;
            quiet_cycles = 0;
          end
        end
        in_ch.valid <= have_cur && !cfg_busy;
        if (have_cur) begin
          in_ch.operation <= cur.op;
          in_ch.slot <= cur.slot;
          in_ch.trigger_position <= cur.trig;
          in_ch.duration <= cur.dur;
          in_ch.target_x <= cur.tgt[0];
          in_ch.target_y <= cur.tgt[1];
          in_ch.target_z <= cur.tgt[2];
          in_ch.target_yaw <= cur.tgt[3];
          in_ch.target_pitch <= cur.tgt[4];
          in_ch.tick_time <= cur.tick;
          in_ch.current_position <= cur.pos;
        end
      end
      res_ch.ready <= $urandom_range(0, 99) >= recv_stall;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    eos_tb_pkg::delta_t e;
    in_fire = rst_ni && in_ch.valid && in_ch.ready;
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        e = predict_delta(cur);
        expected_deltas.push_back(e);
      end
      if (res_ch.valid && res_ch.ready) begin
        if (expected_deltas.size() == 0) report("unexpected result", 0, 0);
        else begin
          e = expected_deltas.pop_front();
          if (res_ch.delta_x !== e.d[0]) report("delta_x", res_ch.delta_x, e.d[0]);
          if (res_ch.delta_y !== e.d[1]) report("delta_y", res_ch.delta_y, e.d[1]);
          if (res_ch.delta_z !== e.d[2]) report("delta_z", res_ch.delta_z, e.d[2]);
          if (res_ch.delta_yaw !== e.d[3]) report("delta_yaw", res_ch.delta_yaw, e.d[3]);
          if (res_ch.delta_pitch !== e.d[4])
            report("delta_pitch", res_ch.delta_pitch, e.d[4]);
          if (res_ch.moved !== e.moved) report("moved", res_ch.moved, e.moved);
          if (res_ch.sequence_done !== e.done)
            report("sequence_done", res_ch.sequence_done, e.done);
        end
      end
    end
  end

  // watchdog on cycles with no handshake at all
  int stuck = 0;
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready) || quiet_cycles > 0)
      stuck <= 0;
    else if (rst_ni && (pending_items.size() > 0 || expected_deltas.size() > 0)) begin
      stuck <= stuck + 1;
      if (stuck >= WatchLimit) begin
        $display("eased_offset_sequencer_unit regression: fail");
        $finish;
      end
    end
  end

  // a short sequence of loads, a count write, then eased ticks with random loads mixed in
  function automatic void build_sequence(input int n, input bit wide);
    int c;
    c = $urandom_range(1, n);
    for (int k = 0; k < c; k++)
      push_load(k, 32'($signed($urandom_range(0, 20)) - 10) << 16,
                $urandom_range(0, 7) == 0 ? 32'd0 : $urandom_range(1, 6) << 16, wide);
    push_cfg(c == 16 && $urandom_range(0, 1) ? 31 : c);
    for (int k = 0; k < 3 * c + 4; k++) begin
      if ($urandom_range(0, 15) == 0) push_load($urandom_range(0, 15), rand_word(), rand_word(), 1);
      else push_tick($urandom_range(0, 5) == 0 ? rand_word() : $urandom_range(0, 3) << 15,
                     32'($signed($urandom_range(0, 24)) - 12) << 16);
    end
  endfunction

  initial begin
    eos_tb_pkg::stim_t s;
    int phase;
    cfg_ch.valid = 1'b0;
    cfg_ch.move_count = '0;
    in_ch.valid = 1'b0;
    in_ch.operation = 1'b0;
    in_ch.slot = '0;
    in_ch.trigger_position = '0;
    in_ch.duration = '0;
    in_ch.target_x = '0;
    in_ch.target_y = '0;
    in_ch.target_z = '0;
    in_ch.target_yaw = '0;
    in_ch.target_pitch = '0;
    in_ch.tick_time = '0;
    in_ch.current_position = '0;
    res_ch.ready = 1'b0;
    restart_run(0);

    // directed: empty sequence tick, then extremes in every slot
    push_tick(32'hFFFF_FFFF, 32'h7FFF_FFFF);
    for (int k = 0; k < 16; k++) begin
      s = blank_item();
      s.op = eos_tb_pkg::OP_LOAD;
      s.slot = 4'(k);
      s.trig = k == 0 ? 32'h8000_0000 : (k == 1 ? 32'h7FFF_FFFF : 32'h0);
      s.dur = k == 2 ? 32'h0 : (k == 3 ? 32'hFFFF_FFFF : 32'h0001_0000);
      for (int a = 0; a < 5; a++)
        s.tgt[a] = k[0] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      pending_items.push_back(s);
    end
    push_cfg(16);
    push_tick(32'h0000_8000, 32'h8000_0000);  // slot 0 trigger at min
    push_tick(32'hFFFF_FFFF, 32'h8000_0000);  // saturating accumulator
    push_tick(32'h0, 32'h7FFF_FFFE);          // below trigger at max
    push_tick(32'h0, 32'h7FFF_FFFF);
    push_tick(32'h0, 32'h0);                  // still below the slot 1 trigger, no time
    s = blank_item();
    s.drain = 1;
    pending_items.push_back(s);
    push_cfg(31);
    push_cfg(0);
    push_tick(32'h1_0000, 32'h0);

    fork
      begin
        repeat (6) @(posedge clk_i);
        @(negedge clk_i) rst_ni = 1'b1;
      end
    join
    phase = 0;
    while (pending_items.size() < 1700) begin
      build_sequence(phase % 7 == 0 ? 16 : 5, phase % 3 == 0);
      phase++;
    end

    // idling phases move on as the queue drains
    for (int ph = 0; ph < 4; ph++) begin
      send_idle = ph == 1 ? 66 : (ph == 3 ? 10 : 0);
      recv_stall = ph == 2 ? 66 : (ph == 3 ? 10 : 0);
      wait (pending_items.size() < 1500 - 400 * ph || pending_items.size() == 0);
    end
    wait (pending_items.size() == 0 && !have_cur && !cfg_busy);
    wait (expected_deltas.size() == 0);
    repeat (Latency) @(posedge clk_i);
    if (errors == 0 && expected_deltas.size() == 0)
      $display("eased_offset_sequencer_unit regression: pass");
    else
      $display("eased_offset_sequencer_unit regression: fail");
    $finish;
  end

endmodule

>>> eased_offset_sequencer_unit.f
+incdir+rtl/core
rtl/core/eos_pkg.sv
rtl/core/eos_if.sv
rtl/core/eos_ram.sv
rtl/core/eos_div.sv
rtl/core/eos_mul.sv
rtl/core/eased_offset_sequencer_unit.sv
tb/eos_tb_if.sv
tb/tb_eased_offset_sequencer_unit.sv
